// ===== rtl/dwfd_pkg.sv =====
package dwfd_pkg;

  // Parser phases, one-hot.
  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_EMPTY_END = 2'd1,
    KIND_PONG      = 2'd2,
    KIND_CLOSED    = 2'd3
  } kind_e;

  // Frame opcodes that the parser acts on.
  localparam logic [3:0] OP_CONT = 4'd0;
  localparam logic [3:0] OP_TEXT = 4'd1;
  localparam logic [3:0] OP_BIN  = 4'd2;
  localparam logic [3:0] OP_PING = 4'd9;

  // Length codes of the second header byte and key size.
  localparam logic [6:0] LEN_16BIT_CODE = 7'd126;
  localparam logic [6:0] LEN_64BIT_CODE = 7'd127;
  localparam logic [3:0] EXT16_BYTES    = 4'd2;
  localparam logic [3:0] EXT64_BYTES    = 4'd8;
  localparam logic [3:0] KEY_BYTES      = 4'd4;

  // Register map.
  localparam int unsigned ADDR_W = 3;
  localparam logic [0:0] REG_MAX_MESSAGE_BYTES = 1'b0;
  localparam logic [0:0] REG_CLIENT_MODE       = 1'b1;
  localparam logic [31:0] MAX_MESSAGE_BYTES_RESET = 32'd33554432;

  // Result queue depth.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Configuration seen by the parser.
  typedef struct packed {
    logic [31:0] max_message_bytes;
    logic        client_mode;
  } cfg_t;

  // One result record: the back end applies the mask byte.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  raw_byte;
    logic [7:0]  mask_byte;
    logic [3:0]  opcode;
    logic        last;
  } rec_t;

endpackage

// ===== rtl/dwfd_front.sv =====
module dwfd_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        rx_byte_i,
  input  dwfd_pkg::cfg_t    cfg_i,
  output logic              res_valid_o,
  output dwfd_pkg::rec_t    res_o
);

  dwfd_pkg::phase_e phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  frame_op_q, frame_op_d;
  logic        masked_q, masked_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] msg_len_q, msg_len_d;
  logic [3:0]  msg_op_q, msg_op_d;
  logic        closed_q, closed_d;

  logic        is_data;
  logic [6:0]  len7;
  logic [63:0] fr_shift;
  logic [63:0] ld_fr;
  logic [63:0] sp_fr;
  logic [31:0] budget;
  logic        over;
  logic        masked_now;
  logic        do_ld;
  logic        do_sp;
  logic        do_close;
  logic        emit_pong;
  logic [7:0]  key_byte;

  assign is_data = (frame_op_q == dwfd_pkg::OP_CONT) || (frame_op_q == dwfd_pkg::OP_TEXT) ||
                   (frame_op_q == dwfd_pkg::OP_BIN);
  assign len7     = rx_byte_i[6:0];
  assign fr_shift = {rem_q[55:0], rx_byte_i};
  assign ld_fr    = (phase_q == dwfd_pkg::PH_HDR1) ? {57'd0, len7} : fr_shift;
  assign masked_now = (phase_q == dwfd_pkg::PH_HDR1) ? rx_byte_i[7] : masked_q;

  // Size limit check on the completed frame length.
  assign budget = cfg_i.max_message_bytes - msg_len_q;
  assign over   = (msg_len_q >= cfg_i.max_message_bytes) || (ld_fr[63:32] != 32'd0) ||
                  (ld_fr[31:0] >= budget);

  // Key byte for the current payload position, most significant first.
  always_comb begin
    case (pos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // Parser next state and result.
  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    frame_op_d = frame_op_q;
    masked_d  = masked_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    key_d     = key_q;
    pos_d     = pos_q;
    msg_len_d = msg_len_q;
    msg_op_d  = msg_op_q;
    closed_d  = closed_q;
    do_ld     = 1'b0;
    do_sp     = 1'b0;
    do_close  = 1'b0;
    emit_pong = 1'b0;
    sp_fr     = ld_fr;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (take_i && !closed_q) begin
      unique case (phase_q)
        dwfd_pkg::PH_HDR0: begin
          fin_d      = rx_byte_i[7];
          frame_op_d = rx_byte_i[3:0];
          phase_d    = dwfd_pkg::PH_HDR1;
        end
        dwfd_pkg::PH_HDR1: begin
          masked_d = rx_byte_i[7];
          if (is_data && (rx_byte_i[7] == cfg_i.client_mode)) begin
            do_close = 1'b1;
          end else begin
            if (is_data && (msg_op_q == dwfd_pkg::OP_CONT)) begin
              msg_op_d = frame_op_q;
            end
            emit_pong = (frame_op_q == dwfd_pkg::OP_PING);
            if ((len7 == dwfd_pkg::LEN_16BIT_CODE) || (len7 == dwfd_pkg::LEN_64BIT_CODE)) begin
              rem_d   = 64'd0;
              cnt_d   = (len7 == dwfd_pkg::LEN_16BIT_CODE) ? dwfd_pkg::EXT16_BYTES :
                                                             dwfd_pkg::EXT64_BYTES;
              phase_d = dwfd_pkg::PH_EXTLEN;
            end else begin
              do_ld = 1'b1;
            end
          end
        end
        dwfd_pkg::PH_EXTLEN: begin
          rem_d = fr_shift;
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            do_ld = 1'b1;
          end
        end
        dwfd_pkg::PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          cnt_d = cnt_q - 4'd1;
          if (cnt_q == 4'd1) begin
            do_sp = 1'b1;
            sp_fr = rem_q;
          end
        end
        dwfd_pkg::PH_PAYLOAD: begin
          pos_d = pos_q + 2'd1;
          rem_d = rem_q - 64'd1;
          if (rem_q == 64'd1) begin
            phase_d = dwfd_pkg::PH_HDR0;
          end
          if (is_data) begin
            res_valid_o      = 1'b1;
            res_o.kind       = dwfd_pkg::KIND_DATA;
            res_o.raw_byte   = rx_byte_i;
            res_o.mask_byte  = masked_q ? key_byte : 8'd0;
            res_o.opcode     = msg_op_d;
            res_o.last       = fin_q && (rem_q == 64'd1);
            if (fin_q && (rem_q == 64'd1)) begin
              msg_len_d = 32'd0;
              msg_op_d  = 4'd0;
            end
          end
        end
        default: begin
          phase_d = dwfd_pkg::PH_HDR0;
        end
      endcase

      // Frame length complete: size check on data frames, then key or payload.
      if (do_ld) begin
        rem_d = ld_fr;
        if (is_data && over) begin
          do_close = 1'b1;
        end else begin
          if (is_data) begin
            msg_len_d = msg_len_q + ld_fr[31:0];
          end
          if (masked_now) begin
            key_d   = 32'd0;
            cnt_d   = dwfd_pkg::KEY_BYTES;
            phase_d = dwfd_pkg::PH_KEY;
          end else begin
            do_sp = 1'b1;
          end
        end
      end

      // Payload start; an empty final data frame ends the message here.
      if (do_sp) begin
        pos_d = 2'd0;
        if (sp_fr == 64'd0) begin
          phase_d = dwfd_pkg::PH_HDR0;
          if (is_data && fin_q) begin
            res_valid_o  = 1'b1;
            res_o.kind   = dwfd_pkg::KIND_EMPTY_END;
            res_o.opcode = msg_op_d;
            res_o.last   = 1'b1;
            msg_len_d    = 32'd0;
            msg_op_d     = 4'd0;
          end
        end else begin
          phase_d = dwfd_pkg::PH_PAYLOAD;
        end
      end

      // A ping answers with a pong request whatever follows.
      if (emit_pong) begin
        res_valid_o  = 1'b1;
        res_o        = '0;
        res_o.kind   = dwfd_pkg::KIND_PONG;
        res_o.opcode = msg_op_d;
      end

      // Protocol violation or size limit closes the connection.
      if (do_close) begin
        closed_d     = 1'b1;
        phase_d      = dwfd_pkg::PH_HDR0;
        res_valid_o  = 1'b1;
        res_o        = '0;
        res_o.kind   = dwfd_pkg::KIND_CLOSED;
        res_o.opcode = msg_op_d;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= dwfd_pkg::PH_HDR0;
      fin_q      <= 1'b0;
      frame_op_q <= 4'd0;
      masked_q   <= 1'b0;
      cnt_q      <= 4'd0;
      rem_q      <= 64'd0;
      key_q      <= 32'd0;
      pos_q      <= 2'd0;
      msg_len_q  <= 32'd0;
      msg_op_q   <= 4'd0;
      closed_q   <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      fin_q      <= fin_d;
      frame_op_q <= frame_op_d;
      masked_q   <= masked_d;
      cnt_q      <= cnt_d;
      rem_q      <= rem_d;
      key_q      <= key_d;
      pos_q      <= pos_d;
      msg_len_q  <= msg_len_d;
      msg_op_q   <= msg_op_d;
      closed_q   <= closed_d;
    end
  end

endmodule

// ===== rtl/dwfd_fifo.sv =====
module dwfd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dwfd_pkg::rec_t  push_data_i,
  input  logic            pop_i,
  output logic            valid_o,
  output dwfd_pkg::rec_t  data_o,
  output logic            full_o
);

  dwfd_pkg::rec_t mem_q [dwfd_pkg::QUEUE_DEPTH];
  logic [dwfd_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [dwfd_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [dwfd_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic do_push;
  logic do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == dwfd_pkg::QCNT_W'(dwfd_pkg::QUEUE_DEPTH));
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update; pointers wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == dwfd_pkg::QPTR_W'(dwfd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + dwfd_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == dwfd_pkg::QPTR_W'(dwfd_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + dwfd_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + dwfd_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - dwfd_pkg::QCNT_W'(1);
    end
  end

  // Queue control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/dwfd_back.sv =====
module dwfd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rec_valid_i,
  input  dwfd_pkg::rec_t  rec_i,
  output logic            rec_pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [3:0]      message_opcode_o,
  output logic            last_of_message_o
);

  logic       valid_q;
  logic [1:0] kind_q;
  logic [7:0] data_q;
  logic [3:0] op_q;
  logic       last_q;

  // Load a new word when the output register is empty or being drained.
  assign rec_pop_o = rec_valid_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (rec_pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Unmask the payload byte on its way into the output register.
  always_ff @(posedge clk_i) begin
    if (rec_pop_o) begin
      kind_q <= rec_i.kind;
      data_q <= rec_i.raw_byte ^ rec_i.mask_byte;
      op_q   <= rec_i.opcode;
      last_q <= rec_i.last;
    end
  end

  assign out_valid_o       = valid_q;
  assign kind_o            = kind_q;
  assign data_byte_o       = data_q;
  assign message_opcode_o  = op_q;
  assign last_of_message_o = last_q;

endmodule

// ===== rtl/websocket_frame_deframer_top.sv =====
// Channel   Direction  Handshake                Payload
// rx        in         rx_valid_i / rx_ready_o  rx_byte_i
// out       out        out_valid_o / out_ready_i kind_o, data_byte_o, message_opcode_o,
//                                               last_of_message_o
// config    in         psel/penable/pwrite      paddr, pwdata, prdata, pready
//
// One received byte is taken every cycle while rx_ready_o is high; the parser handles each byte combinationally.
// A result word passes through the result queue and then the output register before it appears at the output.
// Reset clears all parser state at once; there is no clearing pass.
// A two-word queue sits between the parser and the output register, so rx_ready_o
// drops only when the queue is full behind a stalled output.
module websocket_frame_deframer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [7:0]                    data_byte_o,
  output logic [3:0]                    message_opcode_o,
  output logic                          last_of_message_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dwfd_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  dwfd_pkg::cfg_t cfg_q;
  dwfd_pkg::rec_t front_rec;
  dwfd_pkg::rec_t queue_rec;
  logic           front_valid;
  logic           queue_valid;
  logic           queue_full;
  logic           queue_pop;
  logic           take;
  logic           cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_message_bytes <= dwfd_pkg::MAX_MESSAGE_BYTES_RESET;
      cfg_q.client_mode       <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        dwfd_pkg::REG_MAX_MESSAGE_BYTES: cfg_q.max_message_bytes <= pwdata;
        dwfd_pkg::REG_CLIENT_MODE:       cfg_q.client_mode       <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    unique case (paddr[2])
      dwfd_pkg::REG_MAX_MESSAGE_BYTES: prdata = cfg_q.max_message_bytes;
      dwfd_pkg::REG_CLIENT_MODE:       prdata = {31'd0, cfg_q.client_mode};
      default:                         prdata = 32'd0;
    endcase
  end

  assign rx_ready_o = !queue_full;
  assign take       = rx_valid_i && rx_ready_o;

  dwfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .rx_byte_i   (rx_byte_i),
    .cfg_i       (cfg_q),
    .res_valid_o (front_valid),
    .res_o       (front_rec)
  );

  dwfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_rec),
    .pop_i       (queue_pop),
    .valid_o     (queue_valid),
    .data_o      (queue_rec),
    .full_o      (queue_full)
  );

  dwfd_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rec_valid_i       (queue_valid),
    .rec_i             (queue_rec),
    .rec_pop_o         (queue_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .data_byte_o       (data_byte_o),
    .message_opcode_o  (message_opcode_o),
    .last_of_message_o (last_of_message_o)
  );

endmodule

// ===== tb/tb_websocket_frame_deframer_top.sv =====
`timescale 1ns / 1ps

module tb_websocket_frame_deframer_top;

  // One output word as the deframer presents it.
  typedef struct packed {
    dwfd_pkg::kind_e kind;
    logic [7:0]      data;
    logic [3:0]      opcode;
    logic            last;
  } deframed_t;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_WORD
  } row_check_e;

  typedef struct packed {
    logic [7:0] rx;
    row_check_e how;
    deframed_t  word;
  } stim_row_t;

  // Encodings of the frame length field.
  typedef enum logic [1:0] {
    LEN_SHORT,
    LEN_EXT16,
    LEN_EXT64
  } len_form_e;

  logic                          clk_i;
  logic                          rst_ni      = 1'b0;
  logic                          rx_valid_i  = 1'b0;
  logic                          rx_ready_o;
  logic [7:0]                    rx_byte_i   = 8'h00;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [1:0]                    kind_o;
  logic [7:0]                    data_byte_o;
  logic [3:0]                    message_opcode_o;
  logic                          last_of_message_o;
  logic                          psel        = 1'b0;
  logic                          penable     = 1'b0;
  logic                          pwrite      = 1'b0;
  logic [dwfd_pkg::ADDR_W-1:0]   paddr       = '0;
  logic [31:0]                   pwdata      = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  websocket_frame_deframer_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rx_valid_i       (rx_valid_i),
    .rx_ready_o       (rx_ready_o),
    .rx_byte_i        (rx_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .kind_o           (kind_o),
    .data_byte_o      (data_byte_o),
    .message_opcode_o (message_opcode_o),
    .last_of_message_o(last_of_message_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // Parser model state and the configuration it runs under.
  dwfd_pkg::phase_e ps_phase = dwfd_pkg::PH_HDR0;
  logic        fr_fin     = 1'b0;
  logic [3:0]  fr_op      = '0;
  logic        fr_masked  = 1'b0;
  logic [3:0]  hdr_left   = '0;
  logic [63:0] fr_left    = '0;
  logic [31:0] key        = '0;
  logic [1:0]  key_pos    = '0;
  logic [31:0] msg_len    = '0;
  logic [3:0]  msg_op     = '0;
  logic        link_closed = 1'b0;
  logic [31:0] cfg_max    = dwfd_pkg::MAX_MESSAGE_BYTES_RESET;
  logic        cfg_client = 1'b0;

  deframed_t   pending_words[$];
  stim_row_t   directed_bytes[$];
  int unsigned mismatches = 0;
  int unsigned bytes_fed  = 0;
  int unsigned send_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_seq   = 0;
  int unsigned hold_seen  = 0;
  int unsigned hold_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2_000_000;
    $display("FAIL websocket_frame_deframer_top");
    $finish;
  end

  task automatic flag(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%s", what);
  endtask

  function automatic deframed_t make_word(input dwfd_pkg::kind_e k, input logic [7:0] d,
                                          input logic l);
    deframed_t w;
    w.kind   = k;
    w.data   = d;
    w.opcode = msg_op;
    w.last   = l;
    return w;
  endfunction

  function automatic bit is_data_op();
    return fr_op == dwfd_pkg::OP_CONT || fr_op == dwfd_pkg::OP_TEXT ||
           fr_op == dwfd_pkg::OP_BIN;
  endfunction

  function automatic bit close_link(output deframed_t w);
    w = make_word(dwfd_pkg::KIND_CLOSED, 8'h00, 1'b0);
    link_closed = 1'b1;
    ps_phase = dwfd_pkg::PH_HDR0;
    return 1'b1;
  endfunction

  // Header done: an empty final data frame ends its message right here.
  function automatic bit payload_start(output deframed_t w);
    w = make_word(dwfd_pkg::KIND_DATA, 8'h00, 1'b0);
    key_pos = '0;
    if (fr_left != '0) begin
      ps_phase = dwfd_pkg::PH_PAYLOAD;
      return 1'b0;
    end
    ps_phase = dwfd_pkg::PH_HDR0;
    if (is_data_op() && fr_fin) begin
      w = make_word(dwfd_pkg::KIND_EMPTY_END, 8'h00, 1'b1);
      msg_len = '0;
      msg_op = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Frame length known: data frames are checked against the message size limit.
  function automatic bit length_complete(output deframed_t w);
    w = make_word(dwfd_pkg::KIND_DATA, 8'h00, 1'b0);
    if (is_data_op()) begin
      if (msg_len >= cfg_max || fr_left >= {32'd0, cfg_max - msg_len}) return close_link(w);
      msg_len = msg_len + fr_left[31:0];
    end
    if (fr_masked) begin
      key = '0;
      hdr_left = dwfd_pkg::KEY_BYTES;
      ps_phase = dwfd_pkg::PH_KEY;
      return 1'b0;
    end
    return payload_start(w);
  endfunction

  // Advances the parser model by one received byte; returns 1 when a word results.
  function automatic bit parse_byte(input logic [7:0] rx, output deframed_t w);
    logic [6:0] len7;
    logic [7:0] v;
    logic       last;
    bit         got;
    w = make_word(dwfd_pkg::KIND_DATA, 8'h00, 1'b0);
    got = 1'b0;
    if (link_closed) return 1'b0;
    case (ps_phase)
      dwfd_pkg::PH_HDR0: begin
        fr_fin = rx[7];
        fr_op = rx[3:0];
        ps_phase = dwfd_pkg::PH_HDR1;
      end
      dwfd_pkg::PH_HDR1: begin
        len7 = rx[6:0];
        fr_masked = rx[7];
        if (is_data_op() && fr_masked == cfg_client) begin
          got = close_link(w);
        end else begin
          if (is_data_op() && msg_op == '0 && fr_op != dwfd_pkg::OP_CONT) msg_op = fr_op;
          fr_left = '0;
          if (len7 == dwfd_pkg::LEN_16BIT_CODE || len7 == dwfd_pkg::LEN_64BIT_CODE) begin
            hdr_left = (len7 == dwfd_pkg::LEN_16BIT_CODE) ? dwfd_pkg::EXT16_BYTES :
                                                            dwfd_pkg::EXT64_BYTES;
            ps_phase = dwfd_pkg::PH_EXTLEN;
          end else begin
            fr_left = {57'd0, len7};
            got = length_complete(w);
          end
          // A ping always answers with a pong request, whatever its length.
          if (fr_op == dwfd_pkg::OP_PING) begin
            w = make_word(dwfd_pkg::KIND_PONG, 8'h00, 1'b0);
            got = 1'b1;
          end
        end
      end
      dwfd_pkg::PH_EXTLEN: begin
        fr_left = {fr_left[55:0], rx};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == '0) got = length_complete(w);
      end
      dwfd_pkg::PH_KEY: begin
        key = {key[23:0], rx};
        hdr_left = hdr_left - 4'd1;
        if (hdr_left == '0) got = payload_start(w);
      end
      dwfd_pkg::PH_PAYLOAD: begin
        v = rx;
        if (fr_masked) v = v ^ key[8*(3 - key_pos) +: 8];
        key_pos = key_pos + 2'd1;
        fr_left = fr_left - 64'd1;
        if (fr_left == '0) ps_phase = dwfd_pkg::PH_HDR0;
        if (is_data_op()) begin
          last = fr_fin && fr_left == '0;
          w = make_word(dwfd_pkg::KIND_DATA, v, last);
          got = 1'b1;
          if (last) begin
            msg_len = '0;
            msg_op = '0;
          end
        end
      end
      default: ps_phase = dwfd_pkg::PH_HDR0;
    endcase
    return got;
  endfunction

  // Offers one byte, with an optional idle gap first, and returns once it is taken.
  task automatic push_byte(input logic [7:0] rx);
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (!rx_ready_o);
  endtask

  task automatic feed(input logic [7:0] rx);
    deframed_t w;
    push_byte(rx);
    bytes_fed++;
    if (parse_byte(rx, w)) pending_words.push_back(w);
  endtask

  // Drops valid and waits until every expected word is out and the pipe is empty.
  task automatic settle();
    rx_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Writes a register, then reads it back and checks the value.
  task automatic reg_write(input logic [0:0] idx, input logic [31:0] val);
    logic [31:0] want;
    want = (idx == dwfd_pkg::REG_CLIENT_MODE) ? {31'd0, val[0]} : val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == dwfd_pkg::REG_CLIENT_MODE) cfg_client = val[0];
    else cfg_max = val;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (prdata !== want)
      flag($sformatf("register %0d readback: expected %08h, got %08h", idx, want, prdata));
    @(posedge clk_i);
  endtask

  task automatic add_row(input logic [7:0] rx, input row_check_e how, input dwfd_pkg::kind_e k,
                         input logic [7:0] d, input logic [3:0] op, input logic l);
    stim_row_t r;
    r.rx          = rx;
    r.how         = how;
    r.word.kind   = k;
    r.word.data   = d;
    r.word.opcode = op;
    r.word.last   = l;
    directed_bytes.push_back(r);
  endtask

  task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                            input logic msk, input len_form_e form, input logic [63:0] len,
                            input int unsigned body);
    int unsigned ext;
    feed({fin, rsv, op});
    case (form)
      LEN_EXT16: begin
        feed({msk, dwfd_pkg::LEN_16BIT_CODE});
        ext = 32'(dwfd_pkg::EXT16_BYTES);
      end
      LEN_EXT64: begin
        feed({msk, dwfd_pkg::LEN_64BIT_CODE});
        ext = 32'(dwfd_pkg::EXT64_BYTES);
      end
      default: begin
        feed({msk, len[6:0]});
        ext = 0;
      end
    endcase
    for (int i = ext; i > 0; i--) feed(len[8*(i-1) +: 8]);
    if (msk) repeat (dwfd_pkg::KEY_BYTES) feed(8'($urandom_range(0, 255)));
    repeat (body) feed(8'($urandom_range(0, 255)));
  endtask

  // Mostly data frames that pass the mask and size checks, the rest control and
  // unknown frames with random mask bits.
  task automatic random_frame();
    logic [3:0]  op;
    logic        fin;
    logic        msk;
    logic [31:0] room;
    int unsigned cap;
    int unsigned len;
    int unsigned sel;
    len_form_e   form;
    sel = $urandom_range(0, 99);
    fin = 1'($urandom_range(0, 1));
    msk = 1'($urandom_range(0, 1));
    if (sel < 70) begin
      case ($urandom_range(0, 2))
        0:       op = dwfd_pkg::OP_CONT;
        1:       op = dwfd_pkg::OP_TEXT;
        default: op = dwfd_pkg::OP_BIN;
      endcase
      fin  = ($urandom_range(0, 99) < 40);
      msk  = ~cfg_client;
      room = cfg_max - msg_len - 32'd1;
      cap  = ($urandom_range(0, 9) == 0) ? 140 : 16;
      len  = $urandom_range(0, (room < cap) ? room : cap);
    end else if (sel < 80) begin
      op  = dwfd_pkg::OP_PING;
      len = $urandom_range(0, 8);
    end else begin
      sel = $urandom_range(3, 14);
      op  = 4'((sel >= dwfd_pkg::OP_PING) ? sel + 1 : sel);
      len = $urandom_range(0, 8);
    end
    sel = $urandom_range(0, 9);
    if (len > 125) form = sel[0] ? LEN_EXT16 : LEN_EXT64;
    else if (sel < 7) form = LEN_SHORT;
    else if (sel < 9) form = LEN_EXT16;
    else form = LEN_EXT64;
    send_frame(fin, 3'($urandom_range(0, 7)), op, msk, form, 64'(len), len);
  endtask

  // One configuration phase: settle, write both registers, optionally a long held-off frame, then random frames.
  task automatic run_phase(input logic [31:0] max_bytes, input logic mode,
                           input int unsigned idle_in, input int unsigned idle_out,
                           input int unsigned goal, input bit squeeze);
    logic [31:0] mode_word;
    int unsigned start;
    settle();
    mode_word = $urandom;
    mode_word[0] = mode;
    reg_write(dwfd_pkg::REG_MAX_MESSAGE_BYTES, max_bytes);
    reg_write(dwfd_pkg::REG_CLIENT_MODE, mode_word);
    send_pct = idle_in;
    stall_pct <= idle_out;
    start = bytes_fed;
    if (squeeze) begin
      // The receiver holds off while a long frame keeps the input busy.
      hold_seq <= hold_seq + 1;
      send_frame(1'b1, 3'd0, dwfd_pkg::OP_BIN, ~cfg_client, LEN_SHORT, 64'd60, 60);
    end
    while (bytes_fed - start < goal) random_frame();
    // An empty final continuation closes any open message before the next phase.
    send_frame(1'b1, 3'd0, dwfd_pkg::OP_CONT, ~cfg_client, LEN_SHORT, 64'd0, 0);
  endtask

  // Closes the connection one way or another, then sends bytes that must be ignored.
  task automatic close_connection();
    logic [63:0] len;
    case ($urandom_range(0, 2))
      0: send_frame(1'b1, 3'd0, dwfd_pkg::OP_TEXT, cfg_client, LEN_SHORT, 64'd3, 3);
      1: begin
        len = {$urandom, $urandom};
        len[63] = 1'b1;
        send_frame(1'b1, 3'd0, dwfd_pkg::OP_BIN, ~cfg_client, LEN_EXT64, len, 3);
      end
      default: send_frame(1'b0, 3'd0, dwfd_pkg::OP_TEXT, ~cfg_client, LEN_EXT64,
                          {32'd0, cfg_max - msg_len}, 3);
    endcase
    repeat (8) feed(8'($urandom_range(0, 255)));
  endtask

  // Output side: random stalls, plus a long hold-off on request.
  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen   <= hold_seq;
      hold_left   <= 150;
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Every accepted word is compared with the oldest expected one.
  always @(posedge clk_i) begin : word_check
    deframed_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_words.size() == 0) begin
        flag($sformatf("unexpected word: kind %0d data %02h opcode %0d last %0b",
                       kind_o, data_byte_o, message_opcode_o, last_of_message_o));
      end else begin
        want = pending_words.pop_front();
        if (kind_o !== want.kind || data_byte_o !== want.data ||
            message_opcode_o !== want.opcode || last_of_message_o !== want.last)
          flag($sformatf({"word mismatch: expected kind %0d data %02h opcode %0d last %0b,",
                          " got kind %0d data %02h opcode %0d last %0b"},
                         want.kind, want.data, want.opcode, want.last,
                         kind_o, data_byte_o, message_opcode_o, last_of_message_o));
      end
    end
  end

  initial begin : stimulus
    deframed_t w;
    bit        got;

    // Masked final text frame: payload extremes, key in rotation.
    add_row(8'h81, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h82, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'hFF, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h00, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'hA5, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h5A, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h00, ROW_WORD,  dwfd_pkg::KIND_DATA, 8'hFF, dwfd_pkg::OP_TEXT, 1'b0);
    add_row(8'hFF, ROW_WORD,  dwfd_pkg::KIND_DATA, 8'hFF, dwfd_pkg::OP_TEXT, 1'b1);
    // Ping with all reserved bits set: pong request, payload skipped.
    add_row(8'hF9, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h01, ROW_WORD,  dwfd_pkg::KIND_PONG, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h77, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    // Binary frame without FIN, then an empty final continuation.
    add_row(8'h02, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h81, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h3C, ROW_PREDICT, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'hC3, ROW_PREDICT, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h96, ROW_PREDICT, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h69, ROW_PREDICT, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h80, ROW_PREDICT, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h80, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h80, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h11, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h22, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h33, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h44, ROW_WORD,  dwfd_pkg::KIND_EMPTY_END, 8'h00, dwfd_pkg::OP_BIN, 1'b1);
    // Unmasked empty close frame: nothing comes out.
    add_row(8'h88, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);
    add_row(8'h00, ROW_QUIET, dwfd_pkg::KIND_DATA, 8'h00, dwfd_pkg::OP_CONT, 1'b0);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[i]) begin
      push_byte(directed_bytes[i].rx);
      got = parse_byte(directed_bytes[i].rx, w);
      if (directed_bytes[i].how == ROW_WORD) pending_words.push_back(directed_bytes[i].word);
      else if (directed_bytes[i].how == ROW_PREDICT && got) pending_words.push_back(w);
    end

    run_phase(dwfd_pkg::MAX_MESSAGE_BYTES_RESET, 1'b0, 0, 0, 70, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b1, 45, 0, 70, 1'b0);
    run_phase(32'd1, 1'b0, 0, 45, 60, 1'b0);
    run_phase(32'd40, 1'b1, 29, 29, 70, 1'b0);
    run_phase(dwfd_pkg::MAX_MESSAGE_BYTES_RESET, 1'b0, 0, 0, 60, 1'b1);
    run_phase($urandom_range(60, 1000), 1'($urandom_range(0, 1)), 29, 29, 70, 1'b0);
    close_connection();
    settle();

    if (mismatches == 0) begin
      $display("PASS websocket_frame_deframer_top");
    end else begin
      $display("FAIL websocket_frame_deframer_top");
    end
    $finish;
  end

endmodule
